// File: hdl/bhte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhte_pkg
// shared constants, codes and control structs of the bucketed hash table
// ----------------------------------------------------------------------------
package bhte_pkg;

   localparam int BUCKETS_DEF   = 8;
   localparam int SLOTS_DEF     = 8;
   localparam int TYPE_BITS_DEF = 4;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 80;
   localparam int COUNT_W    = 7;

   localparam logic [1:0] MODE_GET = 2'd0;
   localparam logic [1:0] MODE_SET = 2'd1;
   localparam logic [1:0] MODE_REM = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_IGN  = 2'd2;
   localparam logic [1:0] STAT_FULL = 2'd3;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_REQ,
      WR_PREV,
      WR_ZAP
   } wr_sel_type;

   typedef enum logic [2:0] {
      RES_KEEP,
      RES_IGN,
      RES_MISS,
      RES_FULL,
      RES_NEW,
      RES_HIT
   } res_sel_type;

   typedef struct packed {
      logic        clr_step;
      logic        load_req;
      logic        idx_inc;
      logic        save_hit;
      logic        save_prev;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        out_load;
      wr_sel_type  wr_sel;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       ignored;
      logic [1:0] mode;
      logic       kt_zero;
      logic       hit;
      logic       idx_last;
      logic       last_is_hole;
      logic       rsp_busy;
   } stat_type;

endpackage
`default_nettype wire

// File: hdl/bucketed_hash_table_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_hash_table_engine_unit
// hash table of BUCKETS buckets by SLOTS packed slots, get / set / remove
// ----------------------------------------------------------------------------
// one request word in, one response word out. after reset the block runs a
// clearing pass over the slot memory, one entry a cycle, and takes no
// request until it ends. a request scans its bucket one slot at a time
// through the registered memory read port, a read state and an evaluate
// state per slot, and no new request is taken until its response is
// loaded; an ignored request goes from the read state to the response.
// remove also walks to the end of the occupied run in the same way, then
// passes a move state and a zap state for the move and the empty write.
// the response sits in an output register so the next request is taken
// while it waits; a request that finishes while the previous response is
// still unaccepted holds until that word leaves.
// ----------------------------------------------------------------------------
module bucketed_hash_table_engine_unit #(
   parameter int BUCKETS   = bhte_pkg::BUCKETS_DEF,
   parameter int SLOTS     = bhte_pkg::SLOTS_DEF,
   parameter int TYPE_BITS = bhte_pkg::TYPE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // key_hash[63:0], key_type[67:64], new_value_type[71:68], new_value_data[135:72]
   input  wire logic [bhte_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // out_value_type[3:0], out_value_data[67:4], entry_total[74:68], zero pad
   output logic      [bhte_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic      [1:0]                      rsp_tuser
);

   // command and status between sequencer and datapath
   bhte_pkg::cmd_type  cmd;
   bhte_pkg::stat_type stat;

   bhte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bhte_datapath #(
      .BUCKETS   (BUCKETS),
      .SLOTS     (SLOTS),
      .TYPE_BITS (TYPE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
`default_nettype wire

// File: hdl/bhte_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhte_ctrl
// sequencer: clear pass, slot scan, write back and result hand-off
// ----------------------------------------------------------------------------
module bhte_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire bhte_pkg::stat_type stat,
   output bhte_pkg::cmd_type       cmd
);

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_READ  = 9'b000000100,
      ST_EVAL  = 9'b000001000,
      ST_RREAD = 9'b000010000,
      ST_REVAL = 9'b000100000,
      ST_MOVE  = 9'b001000000,
      ST_ZAP   = 9'b010000000,
      ST_RESP  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.wr_sel  = bhte_pkg::WR_NONE;
      cmd.res_sel = bhte_pkg::RES_KEEP;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            cmd.wr_sel   = bhte_pkg::WR_CLEAR;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            if (stat.ignored) begin
               cmd.res_sel = bhte_pkg::RES_IGN;
               state_in    = ST_RESP;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (stat.mode == bhte_pkg::MODE_SET) begin
               if (stat.kt_zero) begin
                  cmd.wr_sel  = bhte_pkg::WR_REQ;
                  cmd.cnt_inc = 1'b1;
                  cmd.res_sel = bhte_pkg::RES_NEW;
                  state_in    = ST_RESP;
               end else if (stat.hit) begin
                  cmd.wr_sel  = bhte_pkg::WR_REQ;
                  cmd.res_sel = bhte_pkg::RES_HIT;
                  state_in    = ST_RESP;
               end else if (stat.idx_last) begin
                  cmd.res_sel = bhte_pkg::RES_FULL;
                  state_in    = ST_RESP;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_READ;
               end
            end else begin
               if (stat.kt_zero) begin
                  cmd.res_sel = bhte_pkg::RES_MISS;
                  state_in    = ST_RESP;
               end else if (stat.hit) begin
                  cmd.res_sel = bhte_pkg::RES_HIT;
                  if (stat.mode == bhte_pkg::MODE_REM) begin
                     cmd.save_hit = 1'b1;
                     if (stat.idx_last) begin
                        state_in = ST_MOVE;
                     end else begin
                        cmd.idx_inc = 1'b1;
                        state_in    = ST_RREAD;
                     end
                  end else begin
                     state_in = ST_RESP;
                  end
               end else if (stat.idx_last) begin
                  cmd.res_sel = bhte_pkg::RES_MISS;
                  state_in    = ST_RESP;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_RREAD: begin
            state_in = ST_REVAL;
         end
         ST_REVAL: begin
            if (stat.kt_zero) begin
               state_in = ST_MOVE;
            end else begin
               cmd.save_prev = 1'b1;
               if (stat.idx_last) begin
                  state_in = ST_MOVE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_RREAD;
               end
            end
         end
         ST_MOVE: begin
            if (!stat.last_is_hole) cmd.wr_sel = bhte_pkg::WR_PREV;
            state_in = ST_ZAP;
         end
         ST_ZAP: begin
            cmd.wr_sel  = bhte_pkg::WR_ZAP;
            cmd.cnt_dec = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule
`default_nettype wire

// File: hdl/bhte_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhte_datapath
// slot memory, request and scan registers, entry counter, result register
// ----------------------------------------------------------------------------
module bhte_datapath #(
   parameter int BUCKETS   = bhte_pkg::BUCKETS_DEF,
   parameter int SLOTS     = bhte_pkg::SLOTS_DEF,
   parameter int TYPE_BITS = bhte_pkg::TYPE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [bhte_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [bhte_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic      [1:0]                        rsp_tuser,
   input  wire bhte_pkg::cmd_type                 cmd,
   output bhte_pkg::stat_type                     stat
);

   localparam int CAP = BUCKETS * SLOTS;
   localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int SW  = $clog2(SLOTS + 1);
   localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);

   typedef struct packed {
      logic [63:0]          hash;
      logic [TYPE_BITS-1:0] kt;
      logic [TYPE_BITS-1:0] vt;
      logic [63:0]          vd;
   } entry_type;

   entry_type mem_ff [CAP];
   entry_type rdata_ff;

   logic [1:0]                  mode_ff;
   entry_type                   req_ff;
   logic [SW-1:0]               idx_ff, hole_ff, last_ff;
   entry_type                   prev_ff;
   logic [AW-1:0]               clr_ff;
   logic [bhte_pkg::COUNT_W-1:0] count_ff;
   logic [1:0]                  res_st_ff;
   logic [TYPE_BITS-1:0]        res_vt_ff;
   logic [63:0]                 res_vd_ff;
   logic                        rsp_valid_ff;
   logic [1:0]                  out_st_ff;
   logic [TYPE_BITS-1:0]        out_vt_ff;
   logic [63:0]                 out_vd_ff;
   logic [bhte_pkg::COUNT_W-1:0] out_cnt_ff;

   logic [BW-1:0]  bucket;
   logic [AW-1:0]  base_addr;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   entry_type      wr_data;
   entry_type      zap_entry;

   assign bucket    = req_ff.hash[BW-1:0] & BMASK;
   assign base_addr = AW'(int'(bucket) * SLOTS);
   assign rd_addr   = AW'(int'(base_addr) + int'(idx_ff));

   always_comb begin
      zap_entry    = prev_ff;
      zap_entry.kt = '0;
   end

   // single write port shared by clear pass, insert/update and remove
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = rd_addr;
      wr_data = req_ff;
      case (cmd.wr_sel)
         bhte_pkg::WR_CLEAR: begin
            wr_addr = clr_ff;
            wr_data = zap_entry;
         end
         bhte_pkg::WR_REQ: begin
            wr_addr = rd_addr;
            wr_data = req_ff;
         end
         bhte_pkg::WR_PREV: begin
            wr_addr = AW'(int'(base_addr) + int'(hole_ff));
            wr_data = prev_ff;
         end
         bhte_pkg::WR_ZAP: begin
            wr_addr = AW'(int'(base_addr) + int'(last_ff));
            wr_data = zap_entry;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rdata_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff    <= req_tuser;
         req_ff.hash <= req_tdata[63:0];
         req_ff.kt   <= TYPE_BITS'(req_tdata[67:64]);
         req_ff.vt   <= TYPE_BITS'(req_tdata[71:68]);
         req_ff.vd   <= req_tdata[135:72];
      end
      if (cmd.load_req) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + SW'(1);
      end
      if (cmd.save_hit) begin
         hole_ff <= idx_ff;
         last_ff <= idx_ff;
         prev_ff <= rdata_ff;
      end else if (cmd.save_prev) begin
         last_ff <= idx_ff;
         prev_ff <= rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.res_sel)
         bhte_pkg::RES_IGN: begin
            res_st_ff <= bhte_pkg::STAT_IGN;
            res_vt_ff <= '0;
            res_vd_ff <= '0;
         end
         bhte_pkg::RES_MISS: begin
            res_st_ff <= bhte_pkg::STAT_MISS;
            res_vt_ff <= '0;
            res_vd_ff <= '0;
         end
         bhte_pkg::RES_FULL: begin
            res_st_ff <= bhte_pkg::STAT_FULL;
            res_vt_ff <= '0;
            res_vd_ff <= '0;
         end
         bhte_pkg::RES_NEW: begin
            res_st_ff <= bhte_pkg::STAT_OK;
            res_vt_ff <= req_ff.vt;
            res_vd_ff <= req_ff.vd;
         end
         bhte_pkg::RES_HIT: begin
            res_st_ff <= bhte_pkg::STAT_OK;
            res_vt_ff <= rdata_ff.vt;
            res_vd_ff <= rdata_ff.vd;
         end
         default: ;
      endcase
   end

   // count wraps at 128, matching the 7-bit total
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.cnt_inc) begin
         count_ff <= count_ff + bhte_pkg::COUNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_ff <= count_ff - bhte_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_st_ff  <= res_st_ff;
         out_vt_ff  <= res_vt_ff;
         out_vd_ff  <= res_vd_ff;
         out_cnt_ff <= count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_st_ff;
   assign rsp_tdata  = {5'd0, out_cnt_ff, out_vd_ff, 4'(out_vt_ff)};

   always_comb begin
      stat.clr_last     = (clr_ff == AW'(CAP - 1));
      stat.ignored      = (req_ff.kt == '0) ||
                          ((mode_ff == bhte_pkg::MODE_SET) && (req_ff.vt == '0));
      stat.mode         = mode_ff;
      stat.kt_zero      = (rdata_ff.kt == '0);
      stat.hit          = (rdata_ff.kt == req_ff.kt) && (rdata_ff.hash == req_ff.hash);
      stat.idx_last     = (idx_ff == SW'(SLOTS - 1));
      stat.last_is_hole = (last_ff == hole_ff);
      stat.rsp_busy     = rsp_valid_ff && !rsp_tready;
   end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bucketed hash table engine
// ----------------------------------------------------------------------------
// a queue of request words feeds a falling-edge driver; a rising-edge monitor
// compares every response word with the oldest prediction from a shadow
// table kept here. stimulus: directed corner requests, then random traffic
// aimed at few hashes per bucket so that hits, refills, full buckets and
// removals with slot moves happen often.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NB    = bhte_pkg::BUCKETS_DEF;
   localparam int NS    = bhte_pkg::SLOTS_DEF;
   localparam int LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] key_hash;
      logic [3:0]  key_type;
      logic [3:0]  val_type;
      logic [63:0] val_data;
   } lookup_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  val_type;
      logic [63:0] val_data;
      logic [6:0]  total;
   } lookup_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [bhte_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [bhte_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   // shadow table
   logic [63:0] tbl_hash  [NB*NS];
   logic [3:0]  tbl_ktype [NB*NS];
   logic [3:0]  tbl_vtype [NB*NS];
   logic [63:0] tbl_vdata [NB*NS];
   int          tbl_count;

   lookup_req_type pending_reqs[$];
   lookup_rsp_type expected_rsps[$];
   logic [63:0] hash_pool[$];
   int  mismatches = 0;
   int  rsp_seen = 0;
   int  cycles = 0;
   int  rem_hits = 0;
   int  full_seen = 0;
   bit  stim_done = 0;
   bit  hold_off = 0;
   bit  req_tready_seen = 0;
   int  drv_gap = 0;
   int  rdy_gap = 0;

   bucketed_hash_table_engine_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predicted response of one request, updating the shadow table
   function automatic lookup_rsp_type table_lookup(lookup_req_type r);
      lookup_rsp_type o;
      int base;
      int s;
      int last;
      o = '0;
      base = int'(r.key_hash[2:0]) * NS;
      if (r.key_type == 4'd0 ||
          (r.mode == bhte_pkg::MODE_SET && r.val_type == 4'd0)) begin
         o.status = bhte_pkg::STAT_IGN;
      end else if (r.mode == bhte_pkg::MODE_SET) begin
         o.status = bhte_pkg::STAT_FULL;
         for (int i = 0; i < NS; i++) begin
            s = base + i;
            if (tbl_ktype[s] == 4'd0) begin
               tbl_ktype[s] = r.key_type;
               tbl_hash[s]  = r.key_hash;
               tbl_vtype[s] = r.val_type;
               tbl_vdata[s] = r.val_data;
               tbl_count++;
               o.status = bhte_pkg::STAT_OK;
               o.val_type = r.val_type;
               o.val_data = r.val_data;
               break;
            end
            if (tbl_hash[s] == r.key_hash && tbl_ktype[s] == r.key_type) begin
               o.status = bhte_pkg::STAT_OK;
               o.val_type = tbl_vtype[s];
               o.val_data = tbl_vdata[s];
               tbl_vtype[s] = r.val_type;
               tbl_vdata[s] = r.val_data;
               break;
            end
         end
         if (o.status == bhte_pkg::STAT_FULL) full_seen++;
      end else begin
         // get, remove, and the spare mode code which acts as get
         o.status = bhte_pkg::STAT_MISS;
         for (int i = 0; i < NS; i++) begin
            s = base + i;
            if (tbl_ktype[s] == 4'd0) break;
            if (tbl_hash[s] == r.key_hash && tbl_ktype[s] == r.key_type) begin
               o.status = bhte_pkg::STAT_OK;
               o.val_type = tbl_vtype[s];
               o.val_data = tbl_vdata[s];
               if (r.mode == bhte_pkg::MODE_REM) begin
                  // last occupied slot fills the hole
                  last = i;
                  while (last + 1 < NS && tbl_ktype[base+last+1] != 4'd0) last++;
                  tbl_ktype[s] = tbl_ktype[base+last];
                  tbl_hash[s]  = tbl_hash[base+last];
                  tbl_vtype[s] = tbl_vtype[base+last];
                  tbl_vdata[s] = tbl_vdata[base+last];
                  tbl_ktype[base+last] = 4'd0;
                  if (tbl_count > 0) tbl_count--;
                  rem_hits++;
               end
               break;
            end
         end
      end
      o.total = 7'(tbl_count);
      return o;
   endfunction

   function automatic lookup_req_type mk_req(logic [1:0] m, logic [63:0] h,
                                             logic [3:0] kt, logic [3:0] vt,
                                             logic [63:0] vd);
      lookup_req_type r;
      r.mode = m; r.key_hash = h; r.key_type = kt; r.val_type = vt; r.val_data = vd;
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   // driver: new word presented at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (drv_gap > 0) begin
               drv_gap <= drv_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_off) begin
               lookup_req_type r;
               r = pending_reqs.pop_front();
               req_tdata <= {r.val_data, r.val_type, r.key_type, r.key_hash};
               req_tuser <= r.mode;
               req_tvalid <= 1'b1;
               drv_gap <= gap_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // acceptance flag and monitor, sampled at the rising edge
   always @(posedge clock) begin
      lookup_req_type r;
      lookup_rsp_type e;
      lookup_rsp_type a;
      cycles <= cycles + 1;
      req_tready_seen <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         r = {req_tuser, req_tdata[63:0], req_tdata[67:64], req_tdata[71:68],
              req_tdata[135:72]};
         expected_rsps.push_back(table_lookup(r));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.status = rsp_tuser;
         a.val_type = rsp_tdata[3:0];
         a.val_data = rsp_tdata[67:4];
         a.total = rsp_tdata[74:68];
         rsp_seen <= rsp_seen + 1;
         if (expected_rsps.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected response word %h", a);
         end else begin
            e = expected_rsps.pop_front();
            if (a !== e) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display({"mismatch: exp st=%0d vt=%0d vd=%h n=%0d, ",
                            "got st=%0d vt=%0d vd=%h n=%0d"},
                     e.status, e.val_type, e.val_data, e.total,
                     a.status, a.val_type, a.val_data, a.total);
            end
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (rdy_gap > 0) begin
         rdy_gap <= rdy_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rdy_gap <= gap_len();
      end
   end

   initial begin
      logic [63:0] h;
      int p;
      foreach (tbl_ktype[i]) begin
         tbl_ktype[i] = 4'd0; tbl_hash[i] = '0; tbl_vtype[i] = '0; tbl_vdata[i] = '0;
      end
      tbl_count = 0;
      // directed: ignores, misses, fill bucket 0 to full, replace, removes
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_GET, 64'd0, 4'd0, 4'd0, 64'd0));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_SET, 64'd8, 4'd1, 4'd0, '1));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_REM, '1, 4'd0, 4'd15, '1));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_GET, '1, 4'd15, 4'd0, 64'd0));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_REM, 64'd3, 4'd2, 4'd0, 64'd0));
      for (int i = 0; i < NS; i++)
         pending_reqs.push_back(mk_req(bhte_pkg::MODE_SET, 64'(i) << 3, 4'(i + 1),
                                       4'(15 - i), rnd64()));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_SET, 64'hF0 << 3, 4'd3, 4'd5, 64'd1));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_SET, 64'd0, 4'd1, 4'd15, '1));
      pending_reqs.push_back(mk_req(2'd3, 64'd0, 4'd1, 4'd0, 64'd0));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_GET, 64'd0, 4'd2, 4'd0, 64'd0));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_REM, 64'd16, 4'd3, 4'd0, 64'd0));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_REM, 64'd56, 4'd8, 4'd0, 64'd0));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_REM, 64'd0, 4'd1, 4'd0, 64'd0));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_GET, 64'd56, 4'd8, 4'd0, 64'd0));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_SET, '1, 4'd15, 4'd15, '1));
      pending_reqs.push_back(mk_req(bhte_pkg::MODE_GET, '1, 4'd15, 4'd0, 64'd0));
      // pool of random hashes, several per bucket
      for (int i = 0; i < 40; i++) hash_pool.push_back(rnd64());
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // wait for the directed part to drain, then hold the sender
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_tvalid);
      hold_off = 1;
      repeat (3) @(posedge clock);
      hold_off = 0;
      for (int i = 0; i < 550; i++) begin
         p = $urandom_range(0, 99);
         h = hash_pool[$urandom_range(0, hash_pool.size() - 1)];
         if (p < 5) h = rnd64();
         if (p < 45)
            pending_reqs.push_back(mk_req(bhte_pkg::MODE_SET, h, 4'($urandom_range(1, 3)),
                                   4'($urandom_range(p < 2 ? 0 : 1, 15)), rnd64()));
         else if (p < 70)
            pending_reqs.push_back(mk_req(bhte_pkg::MODE_REM, h,
                                   4'($urandom_range(p < 47 ? 0 : 1, 3)),
                                   4'($urandom()), rnd64()));
         else
            pending_reqs.push_back(mk_req(2'($urandom_range(0, 3) == 3 ? 3 : 0), h,
                                   4'($urandom_range(0, 3)), 4'($urandom()), rnd64()));
         if (i == 275) begin
            wait (pending_reqs.size() == 0);
            hold_off = 1;
            wait (expected_rsps.size() == 0 && !req_tvalid);
            hold_off = 0;
         end
      end
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_rsps.size() == 0);
      repeat (40) @(posedge clock);
      stim_done = 1;
   end

   // end of run
   initial begin
      wait (stim_done || cycles >= LIMIT);
      if (!stim_done) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         $display("covered %0d responses, %0d removal hits, %0d full-bucket sets",
                  rsp_seen, rem_hits, full_seen);
         if (mismatches == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
         else
            $display("CHECKS FAILED");
         $finish;
      end
   end
endmodule
